>>> sv/pdsb_pkg.sv
// Shared types, constants and helpers for the Pelco-D to S.BUS bridge.
`default_nettype none

package pdsb_pkg;

   // request operation codes
   localparam logic OP_RX_BYTE = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   // result kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_SBUS   = 1'b1;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] REG_MOUNT_INVERTED  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FOCUS_STEP      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FAILSAFE_FLAG   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LOST_FRAME_FLAG = 2'd3;

   localparam logic [7:0] FOCUS_STEP_RESET = 8'd25;

   // Pelco-D frame positions
   localparam logic [2:0] POS_CMD1  = 3'd2;
   localparam logic [2:0] POS_CMD2  = 3'd3;
   localparam logic [2:0] POS_PAN   = 3'd4;
   localparam logic [2:0] POS_TILT  = 3'd5;
   localparam logic [2:0] POS_LAST  = 3'd6;

   localparam logic [10:0] STOP_SUM    = 11'd257;
   localparam logic [10:0] LENS_MIN    = 11'd352;
   localparam logic [10:0] LENS_MAX    = 11'd1696;
   localparam logic [10:0] LENS_CENTER = 11'd1024;

   // S.BUS frame layout
   localparam int         SBUS_CHAN_BITS = 176;
   localparam logic [7:0] SBUS_HEADER    = 8'h0F;
   localparam logic [4:0] SBUS_FLAGS_IDX = 5'd23;
   localparam logic [4:0] SBUS_LAST_IDX  = 5'd24;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic {CMD_DECODE, CMD_TICK} cmd_op_type;

   typedef enum logic {BACK_IDLE, BACK_SEND} back_state_type;

   typedef struct packed {
      cmd_op_type op;
      logic       stop;
      logic [7:0] cmd1;
      logic [7:0] cmd2;
      logic [7:0] pan_speed;
      logic [7:0] tilt_speed;
   } cmd_type;

   typedef struct packed {
      logic       mount_inverted;
      logic [7:0] focus_step;
      logic       failsafe_flag;
      logic       lost_frame_flag;
   } cfg_type;

   // x*255/63 saturated: 255 = 4*63 + 3, so below 63 it is 4x + x/21
   function automatic logic [7:0] scale_speed(input logic [7:0] x);
      logic [1:0] frac;
      frac = (x >= 8'd42) ? 2'd2 : ((x >= 8'd21) ? 2'd1 : 2'd0);
      if (x >= 8'd63) begin
         return 8'hFF;
      end
      return {x[5:0], 2'b00} + {6'd0, frac};
   endfunction

endpackage

`default_nettype wire

>>> sv/pdsb_if.sv
// Request and result channel interfaces of the bridge.
`default_nettype none

interface pdsb_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] rx_byte;

   modport source (output valid, output operation, output rx_byte, input ready);
   modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface pdsb_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] sbus_byte;
   logic       last;
   logic [7:0] pan_duty;
   logic       pan_dir;
   logic [7:0] tilt_duty;
   logic       tilt_dir;

   modport source (output valid, output kind, output sbus_byte, output last,
                   output pan_duty, output pan_dir, output tilt_duty, output tilt_dir,
                   input ready);
   modport sink   (input valid, input kind, input sbus_byte, input last,
                   input pan_duty, input pan_dir, input tilt_duty, input tilt_dir,
                   output ready);
endinterface

`default_nettype wire

>>> sv/pdsb_front.sv
// Front end: collects Pelco-D bytes into frames and queues decode and tick commands.
`default_nettype none

module pdsb_front import pdsb_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   pdsb_req_if.sink  req,
   input  wire logic q_full,
   output logic      q_push,
   output cmd_type   q_cmd
);

   logic [2:0]  count_ff, count_in;
   logic [10:0] sum_ff, sum_in;
   logic [7:0]  cmd1_ff, cmd2_ff, pan_ff, tilt_ff;
   logic        accept, is_byte, frame_done;
   logic [10:0] total;

   assign req.ready  = !q_full;
   assign accept     = req.valid && !q_full;
   assign is_byte    = accept && (req.operation == OP_RX_BYTE);
   assign frame_done = is_byte && (count_ff == POS_LAST);
   assign total      = sum_ff + {3'd0, req.rx_byte};

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      if (is_byte) begin
         count_in = frame_done ? 3'd0 : count_ff + 3'd1;
         sum_in   = (count_ff == 3'd0) ? {3'd0, req.rx_byte} : total;
      end
   end

   assign q_push = accept && ((req.operation == OP_TICK) || frame_done);

   always_comb begin
      q_cmd.op         = (req.operation == OP_TICK) ? CMD_TICK : CMD_DECODE;
      q_cmd.stop       = (total == STOP_SUM);
      q_cmd.cmd1       = cmd1_ff;
      q_cmd.cmd2       = cmd2_ff;
      q_cmd.pan_speed  = scale_speed(pan_ff);
      q_cmd.tilt_speed = scale_speed(tilt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (is_byte && count_ff == POS_CMD1) begin
         cmd1_ff <= req.rx_byte;
      end
      if (is_byte && count_ff == POS_CMD2) begin
         cmd2_ff <= req.rx_byte;
      end
      if (is_byte && count_ff == POS_PAN) begin
         pan_ff <= req.rx_byte;
      end
      if (is_byte && count_ff == POS_TILT) begin
         tilt_ff <= req.rx_byte;
      end
   end

endmodule

`default_nettype wire

>>> sv/pdsb_queue.sv
// Command queue between front and back ends.
`default_nettype none

module pdsb_queue import pdsb_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      pop_cmd,
   output logic         empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

>>> sv/pdsb_back.sv
// Back end: applies decoded frames to motor and lens state, streams S.BUS frames.
`default_nettype none

module pdsb_back import pdsb_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    q_empty,
   input  wire cmd_type q_cmd,
   output logic         q_pop,
   pdsb_rsp_if.source   rsp
);

   back_state_type            state_ff, state_in;
   logic [4:0]                byte_idx_ff, byte_idx_in;
   logic [SBUS_CHAN_BITS-1:0] chan_bits_ff, chan_bits_in;
   logic [7:0]                pan_speed_ff, pan_speed_in, tilt_speed_ff, tilt_speed_in;
   logic [7:0]                pan_drive_ff, pan_drive_in, tilt_drive_ff, tilt_drive_in;
   logic                      pan_level_ff, pan_level_in, tilt_level_ff, tilt_level_in;
   logic [10:0]               iris_ff, iris_in, focus_ff, focus_in, zoom_ff, zoom_in;
   logic                      out_valid_ff, out_valid_in;
   logic                      out_kind_ff, out_kind_in, out_last_ff, out_last_in;
   logic [7:0]                out_byte_ff, out_byte_in;

   logic       out_free, load, do_decode, start_tick, send_step;
   logic       load_kind, load_last;
   logic [7:0] load_byte, send_byte;
   logic [10:0] focus_near;
   logic        m;

   assign out_free = !out_valid_ff || rsp.ready;
   assign m        = cfg.mount_inverted;

   always_comb begin
      if (byte_idx_ff == SBUS_FLAGS_IDX) begin
         send_byte = {4'd0, cfg.failsafe_flag, cfg.lost_frame_flag, 2'd0};
      end else if (byte_idx_ff == SBUS_LAST_IDX) begin
         send_byte = 8'd0;
      end else begin
         send_byte = chan_bits_ff[7:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (out_free && !q_empty && q_cmd.op == CMD_TICK) begin
               state_in = BACK_SEND;
            end
         end
         BACK_SEND: begin
            if (out_free && byte_idx_ff == SBUS_LAST_IDX) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop      = 1'b0;
      load       = 1'b0;
      do_decode  = 1'b0;
      start_tick = 1'b0;
      send_step  = 1'b0;
      load_kind  = KIND_STATUS;
      load_byte  = 8'd0;
      load_last  = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            if (out_free && !q_empty) begin
               q_pop = 1'b1;
               load  = 1'b1;
               if (q_cmd.op == CMD_TICK) begin
                  start_tick = 1'b1;
                  load_kind  = KIND_SBUS;
                  load_byte  = SBUS_HEADER;
               end else begin
                  do_decode = 1'b1;
               end
            end
         end
         BACK_SEND: begin
            if (out_free) begin
               load      = 1'b1;
               send_step = 1'b1;
               load_kind = KIND_SBUS;
               load_byte = send_byte;
               load_last = (byte_idx_ff == SBUS_LAST_IDX);
            end
         end
         default: begin
         end
      endcase
   end

   // frame decode; stop first, then speeds, directions and lens in order
   always_comb begin
      pan_speed_in  = pan_speed_ff;
      tilt_speed_in = tilt_speed_ff;
      pan_drive_in  = pan_drive_ff;
      tilt_drive_in = tilt_drive_ff;
      pan_level_in  = pan_level_ff;
      tilt_level_in = tilt_level_ff;
      iris_in       = iris_ff;
      focus_in      = focus_ff;
      zoom_in       = zoom_ff;
      focus_near    = focus_ff;
      if (do_decode) begin
         if (q_cmd.stop) begin
            pan_drive_in  = 8'd0;
            tilt_drive_in = 8'd0;
            iris_in       = LENS_CENTER;
            zoom_in       = LENS_CENTER;
         end
         if (!q_cmd.cmd2[0]) begin
            pan_speed_in  = q_cmd.pan_speed;
            tilt_speed_in = q_cmd.tilt_speed;
         end
         if (q_cmd.cmd2[1]) begin
            pan_drive_in = pan_speed_in;
            pan_level_in = m;
         end
         if (q_cmd.cmd2[2]) begin
            pan_drive_in = pan_speed_in;
            pan_level_in = !m;
         end
         if (q_cmd.cmd2[3]) begin
            tilt_drive_in = tilt_speed_in;
            tilt_level_in = m;
         end
         if (q_cmd.cmd2[4]) begin
            tilt_drive_in = tilt_speed_in;
            tilt_level_in = !m;
         end
         if (q_cmd.cmd1[2]) begin
            iris_in = LENS_MIN;
         end
         if (q_cmd.cmd1[1]) begin
            iris_in = LENS_MAX;
         end
         if (q_cmd.cmd1[0] && focus_ff > LENS_MIN) begin
            focus_near = focus_ff - {3'd0, cfg.focus_step};
         end
         focus_in = focus_near;
         if (q_cmd.cmd2[7] && focus_near < LENS_MAX) begin
            focus_in = focus_near + {3'd0, cfg.focus_step};
         end
         if (q_cmd.cmd2[6]) begin
            zoom_in = LENS_MIN;
         end
         if (q_cmd.cmd2[5]) begin
            zoom_in = LENS_MAX;
         end
      end
   end

   always_comb begin
      byte_idx_in  = byte_idx_ff;
      chan_bits_in = chan_bits_ff;
      if (start_tick) begin
         byte_idx_in  = 5'd1;
         // channel 0 in the low bits; iris, focus, zoom on channels 1..3
         chan_bits_in = {{12{LENS_CENTER}}, zoom_ff, focus_ff, iris_ff, LENS_CENTER};
      end else if (send_step) begin
         byte_idx_in  = byte_idx_ff + 5'd1;
         chan_bits_in = chan_bits_ff >> 8;
      end
      out_valid_in = load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
      out_kind_in  = load ? load_kind : out_kind_ff;
      out_byte_in  = load ? load_byte : out_byte_ff;
      out_last_in  = load ? load_last : out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BACK_IDLE;
         byte_idx_ff   <= 5'd0;
         out_valid_ff  <= 1'b0;
         pan_speed_ff  <= 8'd0;
         tilt_speed_ff <= 8'd0;
         pan_drive_ff  <= 8'd0;
         tilt_drive_ff <= 8'd0;
         pan_level_ff  <= 1'b0;
         tilt_level_ff <= 1'b0;
         iris_ff       <= LENS_CENTER;
         focus_ff      <= LENS_CENTER;
         zoom_ff       <= LENS_CENTER;
      end else begin
         state_ff      <= state_in;
         byte_idx_ff   <= byte_idx_in;
         out_valid_ff  <= out_valid_in;
         pan_speed_ff  <= pan_speed_in;
         tilt_speed_ff <= tilt_speed_in;
         pan_drive_ff  <= pan_drive_in;
         tilt_drive_ff <= tilt_drive_in;
         pan_level_ff  <= pan_level_in;
         tilt_level_ff <= tilt_level_in;
         iris_ff       <= iris_in;
         focus_ff      <= focus_in;
         zoom_ff       <= zoom_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_bits_ff <= chan_bits_in;
      out_kind_ff  <= out_kind_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
   end

   // drive state only changes on a pop, which waits for a free output slot
   assign rsp.valid     = out_valid_ff;
   assign rsp.kind      = out_kind_ff;
   assign rsp.sbus_byte = out_byte_ff;
   assign rsp.last      = out_last_ff;
   assign rsp.pan_duty  = pan_drive_ff;
   assign rsp.pan_dir   = pan_level_ff;
   assign rsp.tilt_duty = tilt_drive_ff;
   assign rsp.tilt_dir  = tilt_level_ff;

endmodule

`default_nettype wire

>>> sv/pelco_d_to_sbus_bridge_unit.sv
// A request that completes a Pelco-D frame is written into the command queue, then popped
// into the output register as its status result; a tick request gives the S.BUS header byte
// the same way, then one byte per cycle while the output is taken. Throughput: one request
// per cycle while the queue is not full; 25 bytes per S.BUS frame, one byte per output slot.
// Reset (synchronous): queue empty, byte count 0, speeds/drives/levels 0, lens 1024,
// registers at mount 0, focus step 25, failsafe 1, lost frame 1.
`default_nettype none

module pelco_d_to_sbus_bridge_unit import pdsb_pkg::*; #(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   pdsb_req_if.sink                    req_chan,
   pdsb_rsp_if.source                  rsp_chan,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   cmd_type push_cmd, pop_cmd;
   logic    push, pop, full, empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MOUNT_INVERTED:  cfg_in.mount_inverted  = csr_wdata[0];
            REG_FOCUS_STEP:      cfg_in.focus_step      = csr_wdata;
            REG_FAILSAFE_FLAG:   cfg_in.failsafe_flag   = csr_wdata[0];
            REG_LOST_FRAME_FLAG: cfg_in.lost_frame_flag = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mount_inverted  <= 1'b0;
         cfg_ff.focus_step      <= FOCUS_STEP_RESET;
         cfg_ff.failsafe_flag   <= 1'b1;
         cfg_ff.lost_frame_flag <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pdsb_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .q_full (full),
      .q_push (push),
      .q_cmd  (push_cmd)
   );

   pdsb_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (empty)
   );

   pdsb_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_empty (empty),
      .q_cmd   (pop_cmd),
      .q_pop   (pop),
      .rsp     (rsp_chan)
   );

endmodule

`default_nettype wire

>>> sv/pdsb_checker.sv
// Port-level checks on the bridge result stream, bound to the top level.
`default_nettype none

module pdsb_checker import pdsb_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_kind,
   input wire logic [7:0] rsp_sbus_byte,
   input wire logic       rsp_last
);

   logic in_frame_ff;
   logic rsp_fire;

   assign rsp_fire = rsp_valid && rsp_ready;

   // set while an S.BUS frame has started but its last byte is not yet taken
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
      end else if (rsp_fire && rsp_kind == KIND_SBUS) begin
         in_frame_ff <= !rsp_last;
      end
   end

   a_valid_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_STATUS |-> rsp_sbus_byte == 8'd0 && !rsp_last)
      else $error("status result carries frame byte or last");

   a_frame_contig: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && in_frame_ff |-> rsp_kind == KIND_SBUS)
      else $error("status result inside an S.BUS frame");

   a_frame_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_SBUS && !in_frame_ff |-> rsp_sbus_byte == SBUS_HEADER
         && !rsp_last)
      else $error("S.BUS frame does not open with header");

endmodule

bind pelco_d_to_sbus_bridge_unit pdsb_checker u_pdsb_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_kind      (rsp_chan.kind),
   .rsp_sbus_byte (rsp_chan.sbus_byte),
   .rsp_last      (rsp_chan.last)
);

`default_nettype wire
